// ===== design/lbp_pkg.sv =====
package lbp_pkg;

	// fixed field widths
	localparam int PIXEL_BITS = 8;
	localparam int PIX_FIELD_W = 8;
	localparam int CODE_W = 8;
	localparam int FW_BITS = 11;
	localparam int FH_BITS = 16;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// geometry defaults
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_FRAME_WIDTH = 640;
	localparam int DEF_FRAME_HEIGHT = 480;
	localparam int MIN_DIM = 3;

	// code bit positions, clockwise from top-left
	localparam int BIT_TOP_LEFT = 7;
	localparam int BIT_TOP = 6;
	localparam int BIT_TOP_RIGHT = 5;
	localparam int BIT_RIGHT = 4;
	localparam int BIT_BOT_RIGHT = 3;
	localparam int BIT_BOT = 2;
	localparam int BIT_BOT_LEFT = 1;
	localparam int BIT_LEFT = 0;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic [PIX_FIELD_W-1:0] pixel_value;
		logic                   frame_start;
	} pix_req_t;

	typedef struct packed {
		code_t pattern_code;
		logic  row_end;
		logic  frame_end;
	} code_req_t;

	// per-pixel control decided from the raster position
	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} pos_flags_t;

endpackage

// ===== design/lbp_ram.sv =====
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/lbp_pos.sv =====
module lbp_pos #(
	parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             step,
	input  logic                             frame_start,
	output logic [CW-1:0]                    col,
	output lbp_pkg::pos_flags_t              flags
);

	localparam int RESET_LAST_COL =
		((lbp_pkg::DEF_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : lbp_pkg::DEF_FRAME_WIDTH) - 1;
	localparam int RESET_LAST_ROW = lbp_pkg::DEF_FRAME_HEIGHT - 1;

	logic [CW-1:0]                 last_col_q;
	logic [lbp_pkg::FH_BITS-1:0]   last_row_q;
	logic [CW-1:0]                 col_q;
	logic [lbp_pkg::FH_BITS-1:0]   row_q;
	logic [lbp_pkg::FW_BITS-1:0]   w_raw;
	logic [lbp_pkg::FH_BITS-1:0]   h_raw;
	logic [CW-1:0]                 last_col_d;
	logic [lbp_pkg::FH_BITS-1:0]   last_row_d;
	logic [lbp_pkg::FH_BITS-1:0]   row_cur;
	logic                          last_col;
	logic                          last_row;

	// clamp the written geometry to last column / last row indexes
	always_comb begin
		w_raw = cfg_data[lbp_pkg::FW_BITS-1:0];
		h_raw = cfg_data[lbp_pkg::FH_BITS-1:0];
		if (w_raw < lbp_pkg::FW_BITS'(lbp_pkg::MIN_DIM)) begin
			last_col_d = CW'(lbp_pkg::MIN_DIM - 1);
		end else if (32'(w_raw) > MAX_WIDTH) begin
			last_col_d = CW'(MAX_WIDTH - 1);
		end else begin
			last_col_d = CW'(w_raw - lbp_pkg::FW_BITS'(1));
		end
		if (h_raw < lbp_pkg::FH_BITS'(lbp_pkg::MIN_DIM)) begin
			last_row_d = lbp_pkg::FH_BITS'(lbp_pkg::MIN_DIM - 1);
		end else begin
			last_row_d = h_raw - lbp_pkg::FH_BITS'(1);
		end
	end

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(RESET_LAST_COL);
			last_row_q <= lbp_pkg::FH_BITS'(RESET_LAST_ROW);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lbp_pkg::REG_FRAME_WIDTH:  last_col_q <= last_col_d;
				lbp_pkg::REG_FRAME_HEIGHT: last_row_q <= last_row_d;
				default: ;
			endcase
		end
	end

	// position of the pixel on the request lines
	always_comb begin
		col      = frame_start ? '0 : col_q;
		row_cur  = frame_start ? '0 : row_q;
		last_col = (col >= last_col_q);
		last_row = (row_cur >= last_row_q);
		flags.emit      = (row_cur >= lbp_pkg::FH_BITS'(2)) && (col >= CW'(2));
		flags.row_end   = last_col;
		flags.frame_end = last_col && last_row;
	end

	// raster counters, wrap at row end and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_cur + lbp_pkg::FH_BITS'(1);
			end else begin
				col_q <= col + CW'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

// ===== design/lbp_window.sv =====
module lbp_window (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  lbp_pkg::pixel_t up,
	input  lbp_pkg::pixel_t mid,
	input  lbp_pkg::pixel_t pix,
	output lbp_pkg::code_t  code
);

	// the two older window columns; the incoming column is the right one
	// index [row][col]: col 0 is the left column, col 1 the center column
	lbp_pkg::pixel_t win_q [3][2];
	lbp_pkg::pixel_t ctr;

	// code of the window after the incoming column is shifted in
	always_comb begin
		ctr = win_q[1][1];
		code = '0;
		code[lbp_pkg::BIT_TOP_LEFT]  = (win_q[0][0] >= ctr);
		code[lbp_pkg::BIT_TOP]       = (win_q[0][1] >= ctr);
		code[lbp_pkg::BIT_TOP_RIGHT] = (up >= ctr);
		code[lbp_pkg::BIT_RIGHT]     = (mid >= ctr);
		code[lbp_pkg::BIT_BOT_RIGHT] = (pix >= ctr);
		code[lbp_pkg::BIT_BOT]       = (win_q[2][1] >= ctr);
		code[lbp_pkg::BIT_BOT_LEFT]  = (win_q[2][0] >= ctr);
		code[lbp_pkg::BIT_LEFT]      = (win_q[1][0] >= ctr);
	end

	// column shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
			end
			win_q[0][1] <= up;
			win_q[1][1] <= mid;
			win_q[2][1] <= pix;
		end
	end

endmodule

// ===== design/lbp_3x3_code_stream.sv =====
// 3x3 local binary pattern over a raster pixel stream. Pixels of a frame of
// frame_width x frame_height (registers 0 and 1, written while idle; width is
// clamped to 3..MAX_WIDTH, height to at least 3) enter in raster order, one
// request per cycle unless stalled; frame_start restarts the position at row 0,
// column 0, and after the last pixel of a frame the position wraps on its own.
// Each interior pixel yields one code (bit 7 top-left, clockwise, to bit 0
// left; a bit is set when the neighbour is >= the center); border pixels yield
// nothing, so a frame gives (height-2) x (width-2) codes, with row_end and
// frame_end marking the last code of a row and of the frame. Each pixel reads
// and writes both line stores exactly once, and its code passes through the
// read stage and the output register. A stalled output holds the pipeline only
// while the output register and the read stage are both full.
module lbp_3x3_code_stream #(
	parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  lbp_pkg::pix_req_t              pix_req,
	output logic                           code_valid,
	input  logic                           code_stall,
	output lbp_pkg::code_req_t             code_req
);

	logic                  accept;
	logic                  adv;
	logic                  go_s1;
	logic [CW-1:0]         col_cur;
	lbp_pkg::pos_flags_t   flags_cur;
	lbp_pkg::pixel_t       pix_cur;

	logic                  valid_s1;
	logic [CW-1:0]         col_s1;
	lbp_pkg::pos_flags_t   flags_s1;
	lbp_pkg::pixel_t       pix_s1;
	logic                  fwd_s1;
	lbp_pkg::pixel_t       fwd_up_s1;
	lbp_pkg::pixel_t       fwd_mid_s1;

	lbp_pkg::pixel_t       rd_upper;
	lbp_pkg::pixel_t       rd_middle;
	lbp_pkg::pixel_t       up_s1;
	lbp_pkg::pixel_t       mid_s1;
	lbp_pkg::code_t        code_s1;

	logic                  code_valid_q;
	lbp_pkg::code_req_t    code_req_q;

	// handshake: the read stage moves on when the output register frees up
	assign adv       = !code_valid_q || !code_stall;
	assign go_s1     = valid_s1 && adv;
	assign pix_stall = valid_s1 && !adv;
	assign accept    = pix_valid && !pix_stall;
	assign pix_cur   = pix_req.pixel_value[lbp_pkg::PIXEL_BITS-1:0];

	// raster position and geometry
	lbp_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (accept),
		.frame_start(pix_req.frame_start),
		.col        (col_cur),
		.flags      (flags_cur)
	);

	// line stores: read at request, written when the read stage retires
	lbp_ram #(
		.WIDTH(lbp_pkg::PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk    (clk),
		.wr_en  (go_s1),
		.wr_addr(col_s1),
		.wr_data(mid_s1),
		.rd_en  (accept),
		.rd_addr(col_cur),
		.rd_data(rd_upper)
	);

	lbp_ram #(
		.WIDTH(lbp_pkg::PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_middle (
		.clk    (clk),
		.wr_en  (go_s1),
		.wr_addr(col_s1),
		.wr_data(pix_s1),
		.rd_en  (accept),
		.rd_addr(col_cur),
		.rd_data(rd_middle)
	);

	// forward the retiring write when a restarted frame reads the same column
	assign up_s1  = fwd_s1 ? fwd_up_s1 : rd_upper;
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : rd_middle;

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col_cur;
			flags_s1   <= flags_cur;
			pix_s1     <= pix_cur;
			fwd_s1     <= go_s1 && (col_s1 == col_cur);
			fwd_up_s1  <= mid_s1;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// 3x3 window and code
	lbp_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (go_s1),
		.up    (up_s1),
		.mid   (mid_s1),
		.pix   (pix_s1),
		.code  (code_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (adv) begin
			code_valid_q <= go_s1 && flags_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			code_req_q.pattern_code <= code_s1;
			code_req_q.row_end      <= flags_s1.row_end;
			code_req_q.frame_end    <= flags_s1.frame_end;
		end
	end

	assign code_valid = code_valid_q;
	assign code_req   = code_req_q;

	// the last code of a frame also closes its row
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (!code_req.frame_end || code_req.row_end))
		else $error("frame_end without row_end");

	// codes come only from pixels past the second column
	a_emit_col: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && flags_s1.emit) |-> (col_s1 >= CW'(2)))
		else $error("code emitted for a border column");

	// a held read stage keeps its column and stays valid
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(col_s1) && $stable(pix_s1)))
		else $error("read stage lost while held");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = lbp_pkg::DEF_MAX_WIDTH;
	localparam int RANDOM_PIXELS = 450;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int GAP_MAX = 19;

	typedef enum logic {STEP_PIXEL, STEP_REG_WRITE} step_kind_t;
	typedef logic [lbp_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [lbp_pkg::CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [lbp_pkg::FW_BITS-1:0] width_word_t;
	typedef logic [lbp_pkg::FH_BITS-1:0] height_word_t;

	typedef struct {
		step_kind_t             kind;
		lbp_pkg::pix_req_t      pix;
		cfg_idx_t               idx;
		cfg_word_t              data;
		int unsigned            gap;
	} stream_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	cfg_idx_t cfg_index = '0;
	cfg_word_t cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	lbp_pkg::pix_req_t pix_req = '0;
	logic code_valid;
	logic code_stall = 1'b0;
	lbp_pkg::code_req_t code_req;

	// planned pixel requests and register writes, in order
	stream_step_t plan_q[$];
	int unsigned gap_max = 0;
	int unsigned plan_pixels = 0;
	int unsigned gen_w, gen_h;
	bit at_origin;

	// expected codes, oldest first
	lbp_pkg::code_req_t pending_codes[$];

	// shadow copy of the block state
	lbp_pkg::pixel_t upper_row [MAX_W];
	lbp_pkg::pixel_t middle_row [MAX_W];
	lbp_pkg::pixel_t win [3][3];
	int unsigned col_pos, row_pos;
	width_word_t width_reg;
	height_word_t height_reg;

	int unsigned wait_count = 0;
	int unsigned quiet_count = 0;
	int unsigned hold_left = 0;
	int unsigned stall_max = 0;
	int unsigned idle_cycles = 0;
	int unsigned error_count = 0;
	int unsigned pixels_in = 0;
	int unsigned codes_out = 0;
	int unsigned reg_writes = 0;

	lbp_3x3_code_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_req(pix_req),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_req(code_req)
	);

	always #2 clk = ~clk;

	function automatic int unsigned clamp_width(input width_word_t w);
		if (w < lbp_pkg::MIN_DIM) return lbp_pkg::MIN_DIM;
		if (w > MAX_W) return MAX_W;
		return 32'(w);
	endfunction

	function automatic int unsigned clamp_height(input height_word_t h);
		return (h < lbp_pkg::MIN_DIM) ? lbp_pkg::MIN_DIM : 32'(h);
	endfunction

	// slide the window by one pixel and form the code of its center
	task automatic step_window(input lbp_pkg::pix_req_t r, output logic produced,
			output lbp_pkg::code_req_t res);
		int unsigned w, h, col, row;
		lbp_pkg::pixel_t up, mid, pix, ctr;
		logic last_col, last_row;
		w = clamp_width(width_reg);
		h = clamp_height(height_reg);
		pix = r.pixel_value[lbp_pkg::PIXEL_BITS-1:0];
		if (r.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		col = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
		row = row_pos;
		up = upper_row[col];
		mid = middle_row[col];
		upper_row[col] = mid;
		middle_row[col] = pix;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = pix;
		last_col = (col >= w - 1);
		last_row = (row >= h - 1);
		// neighbour at or above the center sets its bit
		ctr = win[1][1];
		res.pattern_code[lbp_pkg::BIT_TOP_LEFT] = (win[0][0] >= ctr);
		res.pattern_code[lbp_pkg::BIT_TOP] = (win[0][1] >= ctr);
		res.pattern_code[lbp_pkg::BIT_TOP_RIGHT] = (win[0][2] >= ctr);
		res.pattern_code[lbp_pkg::BIT_RIGHT] = (win[1][2] >= ctr);
		res.pattern_code[lbp_pkg::BIT_BOT_RIGHT] = (win[2][2] >= ctr);
		res.pattern_code[lbp_pkg::BIT_BOT] = (win[2][1] >= ctr);
		res.pattern_code[lbp_pkg::BIT_BOT_LEFT] = (win[2][0] >= ctr);
		res.pattern_code[lbp_pkg::BIT_LEFT] = (win[1][0] >= ctr);
		res.row_end = last_col;
		res.frame_end = last_col && last_row;
		produced = (row >= 2) && (col >= 2);
		// advance the raster position, wrapping at row and frame end
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : ((row + 1) & 32'hFFFF);
		end else begin
			col_pos = (col + 1) & 32'h3FF;
			row_pos = row;
		end
	endtask

	task automatic add_pixel(input lbp_pkg::pixel_t v, input logic fs);
		stream_step_t s;
		s.kind = STEP_PIXEL;
		s.pix.pixel_value = v;
		s.pix.frame_start = fs;
		s.idx = '0;
		s.data = '0;
		s.gap = $urandom_range(0, gap_max);
		plan_q.push_back(s);
		plan_pixels++;
	endtask

	task automatic add_reg_write(input cfg_idx_t idx, input cfg_word_t data);
		stream_step_t s;
		s.kind = STEP_REG_WRITE;
		s.pix = '0;
		s.idx = idx;
		s.data = data;
		s.gap = 0;
		plan_q.push_back(s);
		if (idx == lbp_pkg::REG_FRAME_WIDTH)
			gen_w = clamp_width(data[lbp_pkg::FW_BITS-1:0]);
		else
			gen_h = clamp_height(data[lbp_pkg::FH_BITS-1:0]);
	endtask

	// flat areas and near ties make the >= comparisons interesting
	function automatic lbp_pkg::pixel_t draw_pixel(input int unsigned flavor,
			input lbp_pkg::pixel_t base);
		case (flavor)
			0: return base;
			1: return base + lbp_pkg::pixel_t'($urandom_range(0, 3));
			default: return lbp_pkg::pixel_t'($urandom);
		endcase
	endfunction

	task automatic add_pixels(input int unsigned count, input logic first_fs, input bit noisy);
		int unsigned flavor;
		lbp_pkg::pixel_t base;
		logic fs;
		flavor = $urandom_range(0, 3);
		base = lbp_pkg::pixel_t'($urandom);
		for (int unsigned i = 0; i < count; i++) begin
			fs = (i == 0) ? first_fs : (noisy && $urandom_range(0, 15) == 0);
			add_pixel(draw_pixel(flavor, base), fs);
		end
	endtask

	// small geometry, sometimes below the minimum or with junk above the width field
	task automatic add_random_geometry();
		cfg_word_t wv, hv;
		case ($urandom_range(0, 9))
			0, 1: wv = cfg_word_t'($urandom_range(0, lbp_pkg::MIN_DIM - 1));
			2: wv = cfg_word_t'($urandom_range(13, 40));
			default: wv = cfg_word_t'($urandom_range(lbp_pkg::MIN_DIM, 12));
		endcase
		if ($urandom_range(0, 3) == 0)
			wv[lbp_pkg::CFG_DATA_W-1:lbp_pkg::FW_BITS] =
				(lbp_pkg::CFG_DATA_W - lbp_pkg::FW_BITS)'($urandom);
		hv = ($urandom_range(0, 4) == 0) ?
			cfg_word_t'($urandom_range(0, lbp_pkg::MIN_DIM - 1)) :
			cfg_word_t'($urandom_range(lbp_pkg::MIN_DIM, 6));
		if ($urandom_range(0, 1)) begin
			add_reg_write(lbp_pkg::REG_FRAME_WIDTH, wv);
			add_reg_write(lbp_pkg::REG_FRAME_HEIGHT, hv);
		end else begin
			add_reg_write(lbp_pkg::REG_FRAME_HEIGHT, hv);
			add_reg_write(lbp_pkg::REG_FRAME_WIDTH, wv);
		end
	endtask

	// pixel request driver and register writes while the block is idle
	always @(posedge clk) begin : pixel_driver
		logic next_valid;
		logic next_wr;
		stream_step_t head;
		next_valid = pix_valid;
		next_wr = 1'b0;
		if (!arst_n) begin
			next_valid = 1'b0;
			wait_count = 0;
			quiet_count = 0;
		end else begin
			if (pix_valid && !pix_stall)
				next_valid = 1'b0;
			if (pix_valid || pending_codes.size() != 0)
				quiet_count = 0;
			else if (quiet_count < DRAIN_CYCLES)
				quiet_count++;
			if (!next_valid && plan_q.size() != 0) begin
				head = plan_q[0];
				if (head.kind == STEP_REG_WRITE) begin
					if (quiet_count >= DRAIN_CYCLES) begin
						cfg_index <= head.idx;
						cfg_data <= head.data;
						next_wr = 1'b1;
						plan_q.delete(0);
					end
				end else if (wait_count < head.gap) begin
					wait_count++;
				end else begin
					pix_req <= head.pix;
					next_valid = 1'b1;
					wait_count = 0;
					plan_q.delete(0);
				end
			end
		end
		pix_valid <= next_valid;
		cfg_wr_en <= next_wr;
	end

	// predict on accepted pixels, check accepted codes, drive output stall
	always @(posedge clk) begin : code_monitor
		lbp_pkg::code_req_t want;
		logic produced;
		if (!arst_n) begin
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[r, c])
				win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = width_word_t'(lbp_pkg::DEF_FRAME_WIDTH);
			height_reg = height_word_t'(lbp_pkg::DEF_FRAME_HEIGHT);
			hold_left = 0;
			idle_cycles = 0;
			code_stall <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == lbp_pkg::REG_FRAME_WIDTH)
					width_reg = cfg_data[lbp_pkg::FW_BITS-1:0];
				else
					height_reg = cfg_data[lbp_pkg::FH_BITS-1:0];
				reg_writes++;
			end
			if (pix_valid && !pix_stall) begin
				step_window(pix_req, produced, want);
				if (produced)
					pending_codes.push_back(want);
				pixels_in++;
			end
			if (code_valid && !code_stall) begin
				codes_out++;
				if (pending_codes.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected code %02h row_end %b frame_end %b at %0t",
							code_req.pattern_code, code_req.row_end, code_req.frame_end, $time);
				end else begin
					want = pending_codes.pop_front();
					if (code_req.pattern_code !== want.pattern_code ||
							code_req.row_end !== want.row_end ||
							code_req.frame_end !== want.frame_end) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("code mismatch at %0t: expected %02h/%b/%b got %02h/%b/%b",
								$time, want.pattern_code, want.row_end, want.frame_end,
								code_req.pattern_code, code_req.row_end, code_req.frame_end);
					end
				end
				hold_left = $urandom_range(0, stall_max);
				// switch between free flow and random stalls now and then
				if ($urandom_range(0, 63) == 0)
					stall_max = (stall_max == 0) ? GAP_MAX : 0;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			code_stall <= (hold_left != 0);
			// watchdog on cycles without any transfer
			if ((pix_valid && !pix_stall) || (code_valid && !code_stall) || cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles, %0d codes outstanding",
					idle_cycles, pending_codes.size());
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int unsigned target, scenario;
		lbp_pkg::pixel_t tie_frame [12];
		gen_w = clamp_width(width_word_t'(lbp_pkg::DEF_FRAME_WIDTH));
		gen_h = lbp_pkg::DEF_FRAME_HEIGHT;
		at_origin = 1;

		// width and height below the minimum both act as 3
		add_reg_write(lbp_pkg::REG_FRAME_WIDTH, 16'd0);
		add_reg_write(lbp_pkg::REG_FRAME_HEIGHT, 16'd2);
		// bright center over a dark surround
		for (int i = 0; i < 9; i++)
			add_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
		// 4x3 frame that follows without frame_start, ties against the center
		add_reg_write(lbp_pkg::REG_FRAME_WIDTH, 16'd4);
		tie_frame = '{8'd255, 8'd0, 8'd128, 8'd0,
			8'd127, 8'd128, 8'd128, 8'd255,
			8'd200, 8'd1, 8'd129, 8'd127};
		foreach (tie_frame[i])
			add_pixel(tie_frame[i], 1'b0);

		// width written above the maximum: the first row wraps at the widest column,
		// then a narrower width finishes the frame so its codes show the wrap
		gap_max = GAP_MAX;
		add_reg_write(lbp_pkg::REG_FRAME_WIDTH, 16'd2047);
		add_reg_write(lbp_pkg::REG_FRAME_HEIGHT, 16'd3);
		add_pixels(MAX_W, 1'b1, 1'b0);
		add_reg_write(lbp_pkg::REG_FRAME_WIDTH, 16'd4);
		add_pixels(2 * 4, 1'b0, 1'b0);
		add_random_geometry();

		target = plan_pixels + RANDOM_PIXELS;
		while (plan_pixels < target) begin
			if ($urandom_range(0, 3) == 0)
				gap_max = (gap_max == 0) ? GAP_MAX : 0;
			scenario = $urandom_range(0, 9);
			case (scenario)
				// broken frame with stray frame_start marks
				6: begin
					add_pixels($urandom_range(1, 2 * gen_w * gen_h), 1'b1, 1'b1);
					at_origin = 0;
				end
				// geometry shrunk in the middle of a frame
				7: begin
					add_pixels(gen_w * $urandom_range(0, gen_h - 1) + $urandom_range(1, gen_w),
						1'b1, 1'b0);
					add_reg_write(lbp_pkg::REG_FRAME_WIDTH,
						cfg_word_t'($urandom_range(lbp_pkg::MIN_DIM, gen_w)));
					add_reg_write(lbp_pkg::REG_FRAME_HEIGHT,
						cfg_word_t'($urandom_range(lbp_pkg::MIN_DIM, gen_h)));
					add_pixels(gen_w * gen_h + $urandom_range(0, gen_w), 1'b0, 1'b0);
					at_origin = 0;
				end
				// tallest frame, cut short by a lower height
				8: begin
					add_reg_write(lbp_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
					add_pixels(gen_w * $urandom_range(3, 5), 1'b1, 1'b0);
					add_reg_write(lbp_pkg::REG_FRAME_HEIGHT,
						cfg_word_t'($urandom_range(lbp_pkg::MIN_DIM, 6)));
					at_origin = 0;
				end
				// back-to-back frames that rely on the wrap
				9: begin
					if (at_origin) begin
						add_pixels(gen_w * gen_h, 1'b0, 1'b0);
						add_pixels(gen_w * gen_h, 1'b0, 1'b0);
					end else begin
						add_pixels(gen_w * gen_h, 1'b1, 1'b0);
					end
					at_origin = 1;
				end
				// whole frame, new geometry half of the time
				default: begin
					if ($urandom_range(0, 1))
						add_random_geometry();
					add_pixels(gen_w * gen_h, at_origin ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0);
					at_origin = 1;
				end
			endcase
		end

		// reset, then let the plan drain and every code arrive
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (plan_q.size() != 0 || pix_valid || pending_codes.size() != 0);
		repeat (4 * DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels streamed with %0d register writes, %0d codes compared",
			pixels_in, reg_writes, codes_out);
		$display("%0d mismatches, %0d codes still outstanding", error_count, pending_codes.size());
		if (error_count == 0 && pending_codes.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
